[hdl/ste_pkg.sv]
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types and constants of the scaler timestamp extender.
// ----------------------------------------------------------------------------
`default_nettype none

package ste_pkg;

  // Counter and ratio formats
  localparam int COUNT_WIDTH     = 32;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int RATIO_W         = 48;
  localparam int FAST_BITS_W     = 6;
  localparam int WRAP_W          = 32;
  localparam int TS_W            = 64;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RATIO_W;

  // Datapath widths
  localparam int SHIFT_W = 7;
  localparam int DIFF_W  = COUNT_WIDTH + 1;
  localparam int RLO_W   = RATIO_W / 2;
  localparam int RHI_W   = RATIO_W - RLO_W;
  localparam int PP_W    = DIFF_W + RHI_W + 1;
  localparam int PROD_W  = DIFF_W + RATIO_W + 1;

  localparam logic [FAST_BITS_W-1:0] FAST_BITS_RST   = FAST_BITS_W'(COUNT_WIDTH);
  localparam logic [RATIO_W-1:0]     FAST_PER_SLOW_RST = RATIO_W'(1) << RATIO_FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_BITS     = 2'd0,
    CFG_FAST_PER_SLOW = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] fast_count;
    logic [COUNT_WIDTH-1:0] slow_count;
  } in_item_t;

  typedef struct packed {
    logic [TS_W-1:0]   timestamp_ticks;
    logic [WRAP_W-1:0] wraps_seen;
  } out_item_t;

  // Effective configuration, already clamped
  typedef struct packed {
    logic [FAST_BITS_W-1:0] bits;
    logic [SHIFT_W-1:0]     shift;
    logic [RATIO_W-1:0]     ratio;
  } cfg_t;

  // Front stage: wrap flag and signed slow delta
  typedef struct packed {
    logic [COUNT_WIDTH-1:0]   fast;
    logic                     wrap_flag;
    logic signed [DIFF_W-1:0] diff;
  } front_t;

  // Scaled slow delta as a full signed product
  typedef struct packed {
    logic [COUNT_WIDTH-1:0]   fast;
    logic                     wrap_flag;
    logic signed [PROD_W-1:0] prod;
  } prod_t;

  // Accumulated wrap count for one item
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] fast;
    logic [WRAP_W-1:0]      wraps;
  } accum_t;

endpackage

`default_nettype wire

[hdl/ste_front.sv]
// ----------------------------------------------------------------------------
// ste_front
// Input stage: keeps the previous counts, detects a fast wrap and forms the
// signed slow-count delta.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire ste_pkg::in_item_t data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output ste_pkg::front_t        data_o
);
  import ste_pkg::*;

  logic                   valid_q;
  front_t                 data_q, data_d;
  logic [COUNT_WIDTH-1:0] prev_fast_q, prev_slow_q;
  logic                   load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d.fast      = data_i.fast_count;
    data_d.wrap_flag = (prev_fast_q != '0) && (data_i.fast_count < prev_fast_q);
    // zero previous slow count means no previous: no slow term
    if (prev_slow_q != '0) begin
      data_d.diff = $signed({1'b0, data_i.slow_count}) - $signed({1'b0, prev_slow_q});
    end else begin
      data_d.diff = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      prev_fast_q <= '0;
      prev_slow_q <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (load) begin
        prev_fast_q <= data_i.fast_count;
        prev_slow_q <= data_i.slow_count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

[hdl/ste_mul.sv]
// ----------------------------------------------------------------------------
// ste_mul
// Two-stage signed-by-unsigned multiply of the slow delta by the ratio:
// two partial products, then their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_mul (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ste_pkg::cfg_t   cfg_i,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire ste_pkg::front_t data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output ste_pkg::prod_t       data_o
);
  import ste_pkg::*;

  logic                   b_valid_q, b_ready, b_load;
  logic [COUNT_WIDTH-1:0] b_fast_q;
  logic                   b_flag_q;
  logic signed [PP_W-1:0] pp_lo_q, pp_hi_q, pp_lo_d, pp_hi_d;

  logic                   c_valid_q, c_ready, c_load;
  prod_t                  c_q, c_d;

  // stage B: partial products over the low and high ratio halves
  assign b_ready = !b_valid_q || c_ready;
  assign b_load  = valid_i && b_ready;
  assign ready_o = b_ready;

  always_comb begin
    pp_lo_d = data_i.diff * $signed({1'b0, cfg_i.ratio[RLO_W-1:0]});
    pp_hi_d = data_i.diff * $signed({1'b0, cfg_i.ratio[RATIO_W-1:RLO_W]});
  end

  // stage C: recombine into the full signed product
  assign c_ready = !c_valid_q || ready_i;
  assign c_load  = b_valid_q && c_ready;

  always_comb begin
    c_d.fast      = b_fast_q;
    c_d.wrap_flag = b_flag_q;
    c_d.prod      = PROD_W'(pp_lo_q) + (PROD_W'(pp_hi_q) <<< RLO_W);
  end

  assign valid_o = c_valid_q;
  assign data_o  = c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid_q <= valid_i;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_fast_q <= data_i.fast;
      b_flag_q <= data_i.wrap_flag;
      pp_lo_q  <= pp_lo_d;
      pp_hi_q  <= pp_hi_d;
    end
    if (c_load) begin
      c_q <= c_d;
    end
  end

endmodule

`default_nettype wire

[hdl/ste_accum.sv]
// ----------------------------------------------------------------------------
// ste_accum
// Wrap-period accumulator: adds the wrap flag and the floored slow term.
// The stage register is also the running wrap count.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_accum (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ste_pkg::cfg_t  cfg_i,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire ste_pkg::prod_t data_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output ste_pkg::accum_t     data_o
);
  import ste_pkg::*;

  logic                     valid_q, load;
  logic [COUNT_WIDTH-1:0]   fast_q;
  logic [WRAP_W-1:0]        wrap_q, wrap_d, slow_inc;
  logic signed [PROD_W-1:0] floored;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    // arithmetic shift gives the floor toward minus infinity
    floored  = data_i.prod >>> cfg_i.shift;
    slow_inc = floored[WRAP_W-1:0];
    wrap_d   = wrap_q + slow_inc + WRAP_W'(data_i.wrap_flag);
  end

  assign valid_o      = valid_q;
  assign data_o.fast  = fast_q;
  assign data_o.wraps = wrap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      wrap_q  <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (load) begin
        wrap_q <= wrap_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      fast_q <= data_i.fast;
    end
  end

endmodule

`default_nettype wire

[hdl/ste_out.sv]
// ----------------------------------------------------------------------------
// ste_out
// Result register: forms fast + (wraps << fast_bits) for the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_out (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ste_pkg::cfg_t   cfg_i,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire ste_pkg::accum_t data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output ste_pkg::out_item_t   data_o
);
  import ste_pkg::*;

  logic      valid_q, load;
  out_item_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    data_d.timestamp_ticks = TS_W'(data_i.fast) + (TS_W'(data_i.wraps) << cfg_i.bits);
    data_d.wraps_seen      = data_i.wraps;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

[hdl/scaler_timestamp_extender.sv]
// ----------------------------------------------------------------------------
// scaler_timestamp_extender
// Extends a wrapping fast scaler count into a 64-bit fast-tick timestamp,
// using the slow scaler to recover wrap periods that were missed.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out, in order. The block takes a new
// event every cycle while no stage stalls, and an event passes through five
// registers (front stage, two multiplier stages, wrap accumulator, result
// register), each stage holding one event and stalling only when it is full
// and the stage after it cannot take its event. The
// wrap count goes up by one when the fast count falls
// below the previous nonzero fast count, and by
// floor((slow - prev_slow) * fast_per_slow / 2^(16 + fast_bits)) when the
// previous slow count is nonzero. A zero previous count means "none yet";
// reset is the run start. fast_bits of 0 acts as 1 and above 32 as 32.
// Write the configuration only while no event is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module scaler_timestamp_extender (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [ste_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ste_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // event input
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire ste_pkg::in_item_t                  in_data_i,
  // timestamp output
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output ste_pkg::out_item_t                      out_data_o
);
  import ste_pkg::*;

  // Configuration registers
  logic [FAST_BITS_W-1:0] fast_bits_q;
  logic [RATIO_W-1:0]     fast_per_slow_q;
  logic [FAST_BITS_W-1:0] bits_eff;
  cfg_t                   cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_bits_q     <= FAST_BITS_RST;
      fast_per_slow_q <= FAST_PER_SLOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FAST_BITS:     fast_bits_q     <= cfg_wdata_i[FAST_BITS_W-1:0];
        CFG_FAST_PER_SLOW: fast_per_slow_q <= cfg_wdata_i[RATIO_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // Clamp fast_bits into 1..COUNT_WIDTH
  always_comb begin
    if (fast_bits_q == '0) begin
      bits_eff = FAST_BITS_W'(1);
    end else if (fast_bits_q > FAST_BITS_W'(COUNT_WIDTH)) begin
      bits_eff = FAST_BITS_W'(COUNT_WIDTH);
    end else begin
      bits_eff = fast_bits_q;
    end
    cfg.bits  = bits_eff;
    cfg.shift = SHIFT_W'(RATIO_FRAC_BITS) + SHIFT_W'(bits_eff);
    cfg.ratio = fast_per_slow_q;
  end

  // Pipeline
  logic   a_valid, a_ready;
  front_t a_data;
  logic   p_valid, p_ready;
  prod_t  p_data;
  logic   d_valid, d_ready;
  accum_t d_data;

  ste_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (a_valid),
    .ready_i (a_ready),
    .data_o  (a_data)
  );

  ste_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (a_valid),
    .ready_o (a_ready),
    .data_i  (a_data),
    .valid_o (p_valid),
    .ready_i (p_ready),
    .data_o  (p_data)
  );

  ste_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (p_valid),
    .ready_o (p_ready),
    .data_i  (p_data),
    .valid_o (d_valid),
    .ready_i (d_ready),
    .data_o  (d_data)
  );

  ste_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (d_valid),
    .ready_o (d_ready),
    .data_i  (d_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // With nothing newer in the accumulator, the pending result carries the
  // running wrap count.
  a_wraps_match_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !d_valid) |-> (out_data_o.wraps_seen == d_data.wraps))
    else $error("output wrap count differs from running wrap count");

  // Input may only stall when the front stage holds an event.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> a_valid)
    else $error("input stalled with empty front stage");

  // Without a previous slow count the slow delta must be zero.
  a_first_diff_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !a_valid && !p_valid && !d_valid && !out_valid_o
     && $past(!rst_ni)) |=> (a_data.diff == '0))
    else $error("slow delta nonzero on first event after reset");
`endif

endmodule

`default_nettype wire

[bench/tb_scaler_timestamp_extender.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scaler_timestamp_extender
// Self-checking bench for the scaler timestamp extender. A short directed
// table covers counter extremes, backward slow counts, clamped fast_bits,
// zero and full-scale ratios and ignored register indexes. It is followed by
// phases of random events under random settings. Every output transfer is
// compared with a hand result or a behavioral model kept in step with inputs.
// ----------------------------------------------------------------------------

module tb_scaler_timestamp_extender;
  import ste_pkg::*;

  // Pipeline depth as documented at the head of the block
  localparam int LATENCY          = 5;
  localparam int RANDOM_PHASES    = 9;
  localparam int EVENTS_PER_PHASE = 204;
  localparam int MAX_REPORTS      = 10;
  localparam int MAX_IDLE         = 12;
  localparam int TIMEOUT_NS       = 2_000_000;

  // Register indexes with no register behind them; writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
  localparam logic [RATIO_W-1:0]   RATIO_MAX       = '1;

  typedef enum logic {ROW_EVENT, ROW_CFG} row_kind_e;

  // One line of the directed table: a register write or an event, the
  // event optionally carrying a hand-computed result
  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    in_item_t               ev;
    bit                     has_exp;
    out_item_t              exp_item;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // DUT signals; everything driven is known from time zero
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  out_item_t             out_data;

  // --------------------------------------------------------------------------
  // Timestamp model state: its own copy of the registers and counters
  // --------------------------------------------------------------------------
  logic [FAST_BITS_W-1:0] mdl_fast_bits = FAST_BITS_RST;
  logic [RATIO_W-1:0]     mdl_ratio     = FAST_PER_SLOW_RST;
  logic [WRAP_W-1:0]      mdl_wraps     = '0;
  logic [COUNT_WIDTH-1:0] mdl_last_fast = '0;
  logic [COUNT_WIDTH-1:0] mdl_last_slow = '0;

  // Timestamps still owed by the DUT, oldest first
  out_item_t expected_ts[$];
  stim_row_t stim_table[$];

  // Free-running scaler counts used to build realistic event streams
  logic [COUNT_WIDTH-1:0] run_fast = '0;
  logic [COUNT_WIDTH-1:0] run_slow = 32'd1;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_events      = 0;
  int unsigned n_checked     = 0;
  int unsigned n_cfg_writes  = 0;
  int unsigned n_mismatch    = 0;

  scaler_timestamp_extender dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Timestamp model
  // --------------------------------------------------------------------------

  // fast_bits as the datapath sees it: 0 behaves as 1, above 32 as 32
  function automatic int unsigned fast_width();
    int unsigned b;
    b = mdl_fast_bits;
    if (b < 1) b = 1;
    if (b > COUNT_WIDTH) b = COUNT_WIDTH;
    return b;
  endfunction

  function automatic void model_cfg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_FAST_BITS:     mdl_fast_bits = data[FAST_BITS_W-1:0];
      CFG_FAST_PER_SLOW: mdl_ratio     = data[RATIO_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the wrap count for one event and form its timestamp
  function automatic out_item_t extend_timestamp(in_item_t ev);
    int unsigned         b;
    longint              slow_delta;
    logic signed [127:0] delta_w;
    logic signed [127:0] ratio_w;
    logic signed [127:0] scaled;
    out_item_t           res;
    b = fast_width();
    // fast count fell below a real previous value: one period rolled over
    if (mdl_last_fast != 0 && ev.fast_count < mdl_last_fast) begin
      mdl_wraps = mdl_wraps + 1'b1;
    end
    // slow clock elapsed time in wrap periods, floored toward minus infinity
    if (mdl_last_slow != 0) begin
      slow_delta = $signed({32'b0, ev.slow_count}) - $signed({32'b0, mdl_last_slow});
      delta_w    = slow_delta;
      ratio_w    = {80'b0, mdl_ratio};
      scaled     = (delta_w * ratio_w) >>> (RATIO_FRAC_BITS + b);
      mdl_wraps  = mdl_wraps + scaled[WRAP_W-1:0];
    end
    mdl_last_fast       = ev.fast_count;
    mdl_last_slow       = ev.slow_count;
    res.wraps_seen      = mdl_wraps;
    // no mask on fast_count: wide counts add straight into the timestamp
    res.timestamp_ticks = TS_W'(ev.fast_count) + (TS_W'(mdl_wraps) << b);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table construction
  // --------------------------------------------------------------------------
  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row.kind     = ROW_CFG;
    row.idx      = idx;
    row.data     = data;
    row.ev       = '0;
    row.has_exp  = 1'b0;
    row.exp_item = '0;
    stim_table.push_back(row);
  endfunction

  function automatic void add_event(logic [COUNT_WIDTH-1:0] fast, logic [COUNT_WIDTH-1:0] slow);
    stim_row_t row;
    row.kind          = ROW_EVENT;
    row.idx           = '0;
    row.data          = '0;
    row.ev.fast_count = fast;
    row.ev.slow_count = slow;
    row.has_exp       = 1'b0;
    row.exp_item      = '0;
    stim_table.push_back(row);
  endfunction

  // Event whose result is obvious by hand; the model still runs on it
  function automatic void add_known_event(logic [COUNT_WIDTH-1:0] fast,
                                          logic [COUNT_WIDTH-1:0] slow,
                                          logic [TS_W-1:0] ts,
                                          logic [WRAP_W-1:0] wraps);
    add_event(fast, slow);
    stim_table[$].has_exp                  = 1'b1;
    stim_table[$].exp_item.timestamp_ticks = ts;
    stim_table[$].exp_item.wraps_seen      = wraps;
  endfunction

  // --------------------------------------------------------------------------
  // Random event source: mostly steadily counting scalers, some noise
  // --------------------------------------------------------------------------
  function automatic in_item_t next_random_event();
    in_item_t    ev;
    logic [63:0] mask;
    logic [63:0] sum;
    int unsigned pick;
    mask = (64'd1 << fast_width()) - 1;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      // counter advancing by a random stride within its own width
      sum      = 64'(run_fast) + (64'($urandom) & (mask >> $urandom_range(0, 6)));
      run_fast = COUNT_WIDTH'(sum & mask);
      if ($urandom_range(0, 3) == 0) begin
        run_slow = run_slow + $urandom_range(0, 4096);
      end else begin
        run_slow = run_slow + $urandom_range(0, 2);
      end
      ev.fast_count = run_fast;
      ev.slow_count = run_slow;
    end else if (pick < 90) begin
      ev.fast_count = $urandom;
      ev.slow_count = $urandom;
    end else begin
      // zero (means "no previous" next time) and all-ones corners
      ev.fast_count = $urandom_range(0, 1) ? '0 : '1;
      case ($urandom_range(0, 2))
        0:       ev.slow_count = '0;
        1:       ev.slow_count = '1;
        default: ev.slow_count = run_slow;
      endcase
    end
    return ev;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers; all of them return at a falling edge
  // --------------------------------------------------------------------------

  // Optional burst of empty cycles ahead of the next input transfer
  task automatic sender_gap();
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, MAX_IDLE)) @(negedge clk);
    end
  endtask

  // Hold the event until the transfer, then log what must come back
  task automatic send_event(in_item_t ev, bit has_exp, out_item_t hand_result);
    out_item_t pred;
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = extend_timestamp(ev);
    expected_ts.push_back(has_exp ? hand_result : pred);
    n_events++;
    @(negedge clk);
  endtask

  // Registers change only with the pipe empty: drain, let it settle, write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (expected_ts.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    model_cfg_write(idx, data);
    n_cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver backpressure in random bursts
  initial begin : ready_driver
    forever begin
      @(negedge clk);
      if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, MAX_IDLE)) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output checker
  // --------------------------------------------------------------------------
  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS) begin
      $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : timestamp_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_ts.size() == 0) begin
        note_mismatch("unexpected transfer, timestamp_ticks", '0, out_data.timestamp_ticks);
      end else begin
        want = expected_ts.pop_front();
        n_checked++;
        if (out_data.timestamp_ticks !== want.timestamp_ticks) begin
          note_mismatch("timestamp_ticks", want.timestamp_ticks, out_data.timestamp_ticks);
        end
        if (out_data.wraps_seen !== want.wraps_seen) begin
          note_mismatch("wraps_seen", 64'(want.wraps_seen), 64'(out_data.wraps_seen));
        end
      end
    end
  end

  // Safety net against a hung handshake
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout: %0d events in, %0d results checked", n_events, n_checked);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [FAST_BITS_W-1:0] fb;
    logic [RATIO_W-1:0]     ratio;
    int unsigned            phase;
    int unsigned            k;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: fast_bits 32, ratio 1.0, so the slow term is
    // floor(delta / 2^32) and the first rows can be worked out by hand.
    add_known_event(32'd5, 32'd0, 64'd5, 32'd0);                    // nothing previous
    add_known_event(32'd3, 32'd0, 64'h1_0000_0003, 32'd1);          // fast dropped: wrap
    add_known_event('1, 32'd1, 64'h1_FFFF_FFFF, 32'd1);             // fast at max
    add_known_event(32'd0, '1, 64'h2_0000_0000, 32'd2);             // slow jump below a period
    add_known_event(32'd0, 32'd1, 64'h1_0000_0000, 32'd1);          // slow backwards: -1
    add_event(32'h8000_0000, 32'h0001_0001);
    add_event(32'h7FFF_FFFF, 32'h1234_5678);
    // full-scale ratio: the slow term dominates and the wrap count rolls over
    add_cfg(CFG_FAST_PER_SLOW, CFG_DATA_W'(RATIO_MAX));
    add_event(32'h0000_1000, '1);
    add_event(32'h0000_0800, 32'd2);
    // narrowest counter, with counts far wider than it
    add_cfg(CFG_FAST_BITS, CFG_DATA_W'(1));
    add_event(32'd1, 32'h8000_0000);
    add_event('1, 32'd1);
    // fast_bits of zero behaves as one
    add_cfg(CFG_FAST_BITS, CFG_DATA_W'(0));
    add_event(32'd0, '1);
    add_event(32'hAAAA_AAAA, 32'h5555_5555);
    // oversized fast_bits clamps to the counter width
    add_cfg(CFG_FAST_BITS, CFG_DATA_W'(6'h3F));
    add_event(32'h5555_5555, 32'hAAAA_AAAA);
    add_cfg(CFG_FAST_BITS, CFG_DATA_W'(33));
    add_event(32'd1, 32'hAAAA_AAAB);
    // zero ratio: slow count contributes nothing
    add_cfg(CFG_FAST_PER_SLOW, '0);
    add_event(32'd2, 32'd3);
    // writes to unused indexes must leave both registers alone
    add_cfg(CFG_IDX_SPARE_A, '1);
    add_cfg(CFG_IDX_SPARE_B, '1);
    add_event(32'd3, 32'h1000_0000);
    add_cfg(CFG_FAST_BITS, CFG_DATA_W'(FAST_BITS_RST));
    add_cfg(CFG_FAST_PER_SLOW, CFG_DATA_W'(FAST_PER_SLOW_RST));

    send_idle_pct = 10;
    recv_idle_pct = 10;
    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        cfg_write(stim_table[i].idx, stim_table[i].data);
      end else begin
        sender_gap();
        send_event(stim_table[i].ev, stim_table[i].has_exp, stim_table[i].exp_item);
      end
    end

    // Random phases, each under its own settings; the last runs flat out
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       fb = 6'd0;
        1:       fb = 6'd1;
        2:       fb = 6'd32;
        3:       fb = FAST_BITS_W'($urandom_range(33, 63));
        default: fb = FAST_BITS_W'($urandom_range(2, 31));
      endcase
      case ($urandom_range(0, 4))
        0:       ratio = '0;
        1:       ratio = RATIO_MAX;
        2:       ratio = FAST_PER_SLOW_RST;
        3:       ratio = RATIO_W'($urandom_range(1, 1 << 20));
        default: ratio = RATIO_W'({$urandom, $urandom});
      endcase
      cfg_write(CFG_FAST_BITS, CFG_DATA_W'(fb));
      cfg_write(CFG_FAST_PER_SLOW, CFG_DATA_W'(ratio));
      if ($urandom_range(0, 3) == 0) begin
        cfg_write($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                  CFG_DATA_W'({$urandom, $urandom}));
      end

      if (phase == RANDOM_PHASES - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       send_idle_pct = 0;
          1:       send_idle_pct = 5;
          2:       send_idle_pct = 20;
          default: send_idle_pct = 50;
        endcase
        case ($urandom_range(0, 3))
          0:       recv_idle_pct = 0;
          1:       recv_idle_pct = 5;
          2:       recv_idle_pct = 15;
          default: recv_idle_pct = 40;
        endcase
      end

      for (k = 0; k < EVENTS_PER_PHASE; k++) begin
        sender_gap();
        send_event(next_random_event(), 1'b0, '0);
      end
    end

    // Drain, then give the pipe time to show any stray transfer
    in_valid <= 1'b0;
    while (expected_ts.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);

    $display("Covered %0d events and %0d checked timestamps over %0d register writes,",
             n_events, n_checked, n_cfg_writes);
    $display("directed corners plus %0d random setting phases; %0d mismatches.",
             RANDOM_PHASES, n_mismatch);
    if (n_mismatch == 0 && expected_ts.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
